// ----- design/uad_pkg.sv -----
// Shared types, constants and rate tables for the autobaud detector.
`timescale 1ns / 1ps

package uad_pkg;

  // Field and counter widths.
  localparam int TICK_W   = 30;
  localparam int RATE_W   = 21;
  localparam int STAT_W   = 3;
  localparam int EDGE_W   = 7;
  localparam int PROD_W   = 38;

  // Detection limits.
  localparam int MAX_EDGES = 80;
  localparam int MIN_EDGES = 8;

  // Divider and rate search sizes.
  localparam int DIV_BITS   = TICK_W;
  localparam int DIV_CNT_W  = $clog2(DIV_BITS);
  localparam int RATE_COUNT = 10;
  localparam int RATE_IDX_W = $clog2(RATE_COUNT);

  localparam logic [TICK_W-1:0] TICK_HZ_RESET = TICK_W'(600000000);

  // Standard rates, and the accepted distance (a sixth of each rate).
  localparam logic [RATE_W-1:0] STD_RATE [RATE_COUNT] = '{
    RATE_W'(9600),   RATE_W'(19200),  RATE_W'(38400),  RATE_W'(57600),
    RATE_W'(115200), RATE_W'(230400), RATE_W'(460800), RATE_W'(921600),
    RATE_W'(1000000), RATE_W'(2000000)
  };
  localparam logic [RATE_W-1:0] RATE_TOL [RATE_COUNT] = '{
    RATE_W'(9600 / 6),   RATE_W'(19200 / 6),  RATE_W'(38400 / 6),
    RATE_W'(57600 / 6),  RATE_W'(115200 / 6), RATE_W'(230400 / 6),
    RATE_W'(460800 / 6), RATE_W'(921600 / 6), RATE_W'(1000000 / 6),
    RATE_W'(2000000 / 6)
  };

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    STAT_FOUND     = 3'd0,
    STAT_NO_IDLE   = 3'd1,
    STAT_NO_START  = 3'd2,
    STAT_FEW_EDGES = 3'd3,
    STAT_OFF_TOL   = 3'd4
  } uad_stat_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      clear_track;
    logic      clr_elapsed;
    logic      inc_elapsed;
    logic      count_tick;
    logic      div_start;
    logic      search_step;
    logic      emit_fail;
    uad_stat_t fail_code;
    logic      emit_judge;
  } uad_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic idle_over;
    logic start_over;
    logic quiet_over;
    logic edge_seen;
    logic max_reached;
    logic few_edges;
    logic div_done;
    logic search_last;
    logic out_valid;
  } uad_stat_bus_t;

endpackage

// ----- design/uad_sample_if.sv -----
// Request channel carrying one line sample per tick.
`timescale 1ns / 1ps

interface uad_sample_if;
  logic valid;
  logic ready;
  logic rx_level;
  logic restart;

  modport source (output valid, output rx_level, output restart, input ready);
  modport sink (input valid, input rx_level, input restart, output ready);
endinterface

// ----- design/uad_result_if.sv -----
// Result channel carrying the detected rate and status.
`timescale 1ns / 1ps

interface uad_result_if import uad_pkg::*;;
  logic              valid;
  logic              ready;
  logic [RATE_W-1:0] baud_rate;
  logic [STAT_W-1:0] status;

  modport source (output valid, output baud_rate, output status, input ready);
  modport sink (input valid, input baud_rate, input status, output ready);
endinterface

// ----- design/uad_divider.sv -----
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module uad_divider import uad_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [TICK_W-1:0] dividend,
  input  logic [TICK_W-1:0] divisor,
  output logic              done,
  output logic [TICK_W-1:0] quotient
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [TICK_W-1:0]    rem;
  logic [TICK_W-1:0]    dvs;
  logic [TICK_W:0]      rem_sh;
  logic                 fits;

  // Shift in the next dividend bit and try the subtraction.
  assign rem_sh = {rem, quotient[TICK_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs};
  assign done   = busy && (cnt == DIV_CNT_W'(DIV_BITS - 1));

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (done) begin
        busy <= 1'b0;
      end
    end
  end

  // Remainder and quotient shift registers.
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
      dvs      <= divisor;
    end else if (busy) begin
      rem      <= fits ? TICK_W'(rem_sh - {1'b0, dvs}) : rem_sh[TICK_W-1:0];
      quotient <= {quotient[TICK_W-2:0], fits};
    end
  end

endmodule

// ----- design/uad_datapath.sv -----
// Tick counters, pulse tracking, rate division, table search and result register.
`timescale 1ns / 1ps

module uad_datapath import uad_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [TICK_W-1:0] cfg_wdata,
  input  logic              rx_level,
  input  uad_cmd_t          cmd,
  output uad_stat_bus_t     sts,
  uad_result_if.source      results
);

  logic [TICK_W-1:0]     tick_hz;
  logic [TICK_W-1:0]     elapsed;
  logic [TICK_W-1:0]     narrowest;
  logic                  prev_level;
  logic [EDGE_W-1:0]     edge_count;
  logic [TICK_W:0]       e1;
  logic [PROD_W-1:0]     e1_w;
  logic [PROD_W-1:0]     tick_w;
  logic [EDGE_W-1:0]     count_inc;
  logic [EDGE_W-1:0]     count_after;
  logic                  div_done;
  logic [TICK_W-1:0]     raw;
  logic [RATE_IDX_W-1:0] idx;
  logic [RATE_IDX_W-1:0] best_idx;
  logic [TICK_W-1:0]     best_diff;
  logic [TICK_W-1:0]     rate_ext;
  logic [TICK_W-1:0]     diff;
  logic                  off_tol;
  logic                  out_valid;
  logic [RATE_W-1:0]     out_rate;
  uad_stat_t             out_stat;

  // Tick frequency register.
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_hz <= TICK_HZ_RESET;
    end else if (cfg_we) begin
      tick_hz <= cfg_wdata;
    end
  end

  // Limit checks: e > T/k holds exactly when k*e > T for whole e.
  assign e1     = {1'b0, elapsed} + 1'b1;
  assign e1_w   = PROD_W'(e1);
  assign tick_w = PROD_W'(tick_hz);

  assign count_inc   = (edge_count == '1) ? edge_count : edge_count + 1'b1;
  assign count_after = sts.edge_seen ? count_inc : edge_count;

  always_comb begin
    sts.idle_over   = ((e1_w << 4) + (e1_w << 2)) > tick_w;
    sts.start_over  = (e1_w << 1) > tick_w;
    sts.quiet_over  = ((e1_w << 6) + (e1_w << 5) + (e1_w << 2)) > tick_w;
    sts.edge_seen   = rx_level != prev_level;
    sts.max_reached = sts.edge_seen && (count_inc >= EDGE_W'(MAX_EDGES));
    sts.few_edges   = count_after < EDGE_W'(MIN_EDGES);
    sts.div_done    = div_done;
    sts.search_last = idx == RATE_IDX_W'(RATE_COUNT - 1);
    sts.out_valid   = out_valid;
  end

  // Elapsed ticks, narrowest pulse and edge count.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_track) begin
      elapsed    <= '0;
      narrowest  <= '1;
      prev_level <= 1'b0;
      edge_count <= '0;
    end else if (cmd.clr_elapsed) begin
      elapsed <= '0;
    end else if (cmd.inc_elapsed) begin
      elapsed <= e1[TICK_W-1:0];
    end else if (cmd.count_tick) begin
      if (sts.edge_seen) begin
        if (e1 < {1'b0, narrowest}) begin
          narrowest <= e1[TICK_W-1:0];
        end
        elapsed    <= '0;
        prev_level <= rx_level;
        edge_count <= count_inc;
      end else begin
        elapsed <= e1[TICK_W-1:0];
      end
    end
  end

  // Raw rate: tick frequency over the narrowest pulse.
  uad_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (tick_hz),
    .divisor  (narrowest),
    .done     (div_done),
    .quotient (raw)
  );

  // Nearest standard rate, one table entry per cycle; ties keep the earlier one.
  assign rate_ext = TICK_W'(STD_RATE[idx]);
  assign diff     = (raw >= rate_ext) ? raw - rate_ext : rate_ext - raw;

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      idx <= '0;
    end else if (cmd.search_step) begin
      idx <= idx + 1'b1;
      if (idx == '0 || diff < best_diff) begin
        best_idx  <= idx;
        best_diff <= diff;
      end
    end
  end

  assign off_tol = best_diff > TICK_W'(RATE_TOL[best_idx]);

  // Output register, loaded once per detection.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_fail || cmd.emit_judge) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_fail) begin
      out_rate <= '0;
      out_stat <= cmd.fail_code;
    end else if (cmd.emit_judge) begin
      out_rate <= off_tol ? '0 : STD_RATE[best_idx];
      out_stat <= off_tol ? STAT_OFF_TOL : STAT_FOUND;
    end
  end

  assign results.valid     = out_valid;
  assign results.baud_rate = out_rate;
  assign results.status    = out_stat;

endmodule

// ----- design/uad_ctrl.sv -----
// Detection sequencer: waits, edge counting, division and search steps.
`timescale 1ns / 1ps

module uad_ctrl import uad_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          fire,
  input  logic          rx_level,
  input  logic          restart,
  input  uad_stat_bus_t sts,
  output logic          ready,
  output uad_cmd_t      cmd
);

  typedef enum logic [7:0] {
    ST_WAIT_HIGH = 8'b0000_0001,
    ST_WAIT_FALL = 8'b0000_0010,
    ST_COUNT     = 8'b0000_0100,
    ST_DIV_GO    = 8'b0000_1000,
    ST_DIV       = 8'b0001_0000,
    ST_SEARCH    = 8'b0010_0000,
    ST_JUDGE     = 8'b0100_0000,
    ST_DONE      = 8'b1000_0000
  } uad_state_t;

  uad_state_t state;
  uad_state_t state_next;
  logic       sampling;

  // Sampling states need a free output slot; the finished state takes any request.
  assign sampling = (state == ST_WAIT_HIGH) || (state == ST_WAIT_FALL) ||
                    (state == ST_COUNT);
  assign ready    = (state == ST_DONE) || (sampling && !sts.out_valid);

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.fail_code = STAT_FOUND;
    case (state)
      ST_WAIT_HIGH: begin
        if (fire) begin
          if (restart) begin
            cmd.clear_track = 1'b1;
          end else if (rx_level) begin
            cmd.clr_elapsed = 1'b1;
            state_next      = ST_WAIT_FALL;
          end else begin
            cmd.inc_elapsed = 1'b1;
            if (sts.idle_over) begin
              cmd.emit_fail = 1'b1;
              cmd.fail_code = STAT_NO_IDLE;
              state_next    = ST_DONE;
            end
          end
        end
      end
      ST_WAIT_FALL: begin
        if (fire) begin
          if (restart) begin
            cmd.clear_track = 1'b1;
            state_next      = ST_WAIT_HIGH;
          end else if (!rx_level) begin
            cmd.clear_track = 1'b1;
            state_next      = ST_COUNT;
          end else begin
            cmd.inc_elapsed = 1'b1;
            if (sts.start_over) begin
              cmd.emit_fail = 1'b1;
              cmd.fail_code = STAT_NO_START;
              state_next    = ST_DONE;
            end
          end
        end
      end
      ST_COUNT: begin
        if (fire) begin
          if (restart) begin
            cmd.clear_track = 1'b1;
            state_next      = ST_WAIT_HIGH;
          end else begin
            cmd.count_tick = 1'b1;
            if (sts.max_reached || (!sts.edge_seen && sts.quiet_over)) begin
              if (sts.few_edges) begin
                cmd.emit_fail = 1'b1;
                cmd.fail_code = STAT_FEW_EDGES;
                state_next    = ST_DONE;
              end else begin
                state_next = ST_DIV_GO;
              end
            end
          end
        end
      end
      ST_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        if (sts.div_done) begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd.search_step = 1'b1;
        if (sts.search_last) begin
          state_next = ST_JUDGE;
        end
      end
      ST_JUDGE: begin
        cmd.emit_judge = 1'b1;
        state_next     = ST_DONE;
      end
      ST_DONE: begin
        if (fire && restart) begin
          cmd.clear_track = 1'b1;
          state_next      = ST_WAIT_HIGH;
        end
      end
      default: begin
        state_next = ST_WAIT_HIGH;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_WAIT_HIGH;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- design/uart_autobaud_detector_unit.sv -----
// Top level of the UART autobaud detector.
`timescale 1ns / 1ps
//
// Each request on the samples channel is one sampling tick: the receive line
// level and a restart flag. A restart request drops any detection in flight
// and starts over. The block waits for an idle high line, then the falling
// start edge, then counts edges and keeps the narrowest pulse.
// Timeouts follow tick_hz, written through cfg_we and cfg_wdata.
// The block takes samples while it waits or counts edges.
// A failure result is registered in the cycle after the sample that caused it.
// A successful count then launches and runs the bit-serial divider, searches
// the rate table and judges the tolerance; no sample is taken in those steps.
// The results channel carries one result per detection from an output
// register. While it waits, the finished block still takes samples, which
// are ignored unless they request a restart; a detection in progress stalls
// its samples until the result has been taken.
// Reset loads tick_hz with 600 MHz and starts a new detection.

module uart_autobaud_detector_unit import uad_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [TICK_W-1:0] cfg_wdata,
  uad_sample_if.sink        samples,
  uad_result_if.source      results
);

  uad_cmd_t      cmd;
  uad_stat_bus_t sts;
  logic          ready;
  logic          fire;

  assign samples.ready = ready;
  assign fire          = samples.valid && ready;

  uad_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .rx_level (samples.rx_level),
    .restart  (samples.restart),
    .sts      (sts),
    .ready    (ready),
    .cmd      (cmd)
  );

  uad_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .rx_level  (samples.rx_level),
    .cmd       (cmd),
    .sts       (sts),
    .results   (results)
  );

endmodule

// ----- design/uad_checker.sv -----
// Port-level checks on the autobaud detector, bound to the top level.
`timescale 1ns / 1ps

module uad_checker import uad_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_restart,
  input logic              out_valid,
  input logic              out_ready,
  input logic [RATE_W-1:0] out_baud,
  input logic [STAT_W-1:0] out_status
);

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // A pending result is not withdrawn.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped before it was taken");

  // A restart request never gives a result of its own.
  a_restart_quiet: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_restart && !out_valid) |=> !out_valid)
    else $error("result after a restart request");

  // Failures carry rate zero, a found rate is nonzero.
  a_rate_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_status == STAT_FOUND) ? (out_baud != '0) : (out_baud == '0)))
    else $error("rate does not match status");

  // Status stays within its codes.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_status == STAT_FOUND || out_status == STAT_NO_IDLE ||
                   out_status == STAT_NO_START || out_status == STAT_FEW_EDGES ||
                   out_status == STAT_OFF_TOL))
    else $error("unknown status code");

endmodule

bind uart_autobaud_detector_unit uad_checker u_uad_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (samples.valid),
  .in_ready   (samples.ready),
  .in_restart (samples.restart),
  .out_valid  (results.valid),
  .out_ready  (results.ready),
  .out_baud   (results.baud_rate),
  .out_status (results.status)
);
